[hdl/wtfd_pkg.sv]
`timescale 1ns / 1ps

package wtfd_pkg;

   localparam int TABLE_DEPTH_DEF = 4096;
   localparam int DELAY_DEPTH_DEF = 16384;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic [1:0] MODE_AUDIO  = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_COMMIT = 2'd2;

   localparam logic [1:0] CSR_INC_SCALE = 2'd0;
   localparam logic [1:0] CSR_SPMS      = 2'd1;
   localparam logic [1:0] CSR_DLEN      = 2'd2;
   localparam logic [1:0] CSR_FLEN      = 2'd3;

   localparam logic [23:0] INC_SCALE_RST = 24'd1431656;
   localparam logic [15:0] SPMS_RST      = 16'd12288;
   localparam logic [14:0] DLEN_RST      = 15'd12001;
   localparam logic [15:0] FLEN_RST      = 16'd24000;

   // Unity gain in Q16 and the odd polynomial coefficients of the fade curve.
   localparam logic [16:0] GAIN_ONE = 17'd65536;
   localparam logic [16:0] FADE_A1  = 17'd102920;
   localparam logic [16:0] FADE_A3  = 17'd42107;
   localparam logic [16:0] FADE_A5  = 17'd4728;

   // Bits shifted through the shared divider.
   localparam int DIV_NUM_W = 17;

endpackage

[hdl/wtfd_ram.sv]
`timescale 1ns / 1ps

module wtfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/wtfd_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. The partial remainder
// must start below the divisor.
module wtfd_div #(
   parameter int RW = 16,
   parameter int NW = 17
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [RW-1:0] rem_init,
   input  logic [NW-1:0] num,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] quot,
   output logic [RW-1:0] rem
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [RW-1:0] rem_ff;
   logic [NW-1:0] num_ff;
   logic [RW-1:0] div_ff;

   logic [RW:0]   trial;
   logic [RW:0]   diff;
   logic          ge;
   logic [RW-1:0] rem_in;
   logic [NW-1:0] num_in;

   assign trial  = {rem_ff, num_ff[NW-1]};
   assign diff   = trial - {1'b0, div_ff};
   assign ge     = trial >= {1'b0, div_ff};
   assign rem_in = ge ? diff[RW-1:0] : trial[RW-1:0];
   assign num_in = {num_ff[NW-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= rem_init;
         num_ff <= num;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign done = done_ff;
   assign quot = num_ff;
   assign rem  = rem_ff;

endmodule

[hdl/wtfd_gain.sv]
`timescale 1ns / 1ps

// Quarter-sine fade gain in Q16, evaluated over four products on one
// shared multiplier.
module wtfd_gain (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] x,
   output logic        done,
   output logic [16:0] g
);

   logic        busy_ff;
   logic        done_ff;
   logic [2:0]  stp_ff;
   logic [16:0] x_ff;
   logic [16:0] x2_ff;
   logic [33:0] prod_ff;
   logic [16:0] g_ff;

   logic [17:0] mid;
   logic [16:0] t_now;
   logic [16:0] u_now;
   logic [16:0] opa;
   logic [16:0] opb;
   logic [33:0] prod_in;

   assign mid   = prod_ff[33:16];
   assign t_now = wtfd_pkg::FADE_A3 - mid[16:0];
   assign u_now = wtfd_pkg::FADE_A1 - mid[16:0];

   always_comb begin
      unique case (stp_ff)
         3'd0: begin
            opa = x_ff;
            opb = x_ff;
         end
         3'd1: begin
            opa = mid[16:0];
            opb = wtfd_pkg::FADE_A5;
         end
         3'd2: begin
            opa = x2_ff;
            opb = t_now;
         end
         3'd3: begin
            opa = x_ff;
            opb = u_now;
         end
         default: begin
            opa = x_ff;
            opb = x_ff;
         end
      endcase
   end

   assign prod_in = opa * opb;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         stp_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            stp_ff  <= '0;
         end else if (busy_ff) begin
            stp_ff <= stp_ff + 1'b1;
            if (stp_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
         if (stp_ff == 3'd1) begin
            x2_ff <= mid[16:0];
         end
         if (stp_ff == 3'd4) begin
            g_ff <= (mid > {1'b0, wtfd_pkg::GAIN_ONE}) ? wtfd_pkg::GAIN_ONE : mid[16:0];
         end
      end
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

[hdl/wavetable_osc_feedback_delay.sv]
`timescale 1ns / 1ps
// Audio beat: the delay may be wrapped into the line with the bit-serial
// remainder unit, and a running crossfade adds a fade ratio division (skipped
// when the ratio is pinned at full scale) and two gain evaluations. Table write,
// commit and ignored beats go straight to the result. One beat is in flight at a
// time. Reset is synchronous; afterwards both memories are zeroed, one entry a
// cycle, over max(DELAY_DEPTH, 2*TABLE_DEPTH) addresses.
module wavetable_osc_feedback_delay #(
   parameter int TABLE_DEPTH = wtfd_pkg::TABLE_DEPTH_DEF,
   parameter int DELAY_DEPTH = wtfd_pkg::DELAY_DEPTH_DEF,
   parameter int SAMPLE_BITS = wtfd_pkg::SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic signed [19:0] req_frequency_hz,
   input  logic signed [16:0] req_delay_ms,
   input  logic signed [15:0] req_feedback_gain,
   input  logic [11:0]        req_table_index,
   input  logic signed [15:0] req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_sample,
   output logic               rsp_sample_valid,
   output logic               rsp_fade_active,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   localparam int SB  = SAMPLE_BITS;
   localparam int TW  = $clog2(TABLE_DEPTH);
   localparam int TAW = TW + 1;
   localparam int DW  = $clog2(DELAY_DEPTH);
   localparam int LW  = DW + 1;
   localparam int LCW = (LW > 15) ? LW : 15;
   localparam int PW  = TW + 16;
   localparam int RW  = (LW > 16) ? LW : 16;
   localparam int DXW = (LW + 17 > 34) ? LW + 17 : 34;
   localparam int IPW = (PW + 12 > 45) ? PW + 12 : 45;
   localparam int IXW = (TW + 1 > 13) ? TW + 1 : 13;
   localparam int TVW = ((SB > 16) ? SB : 16) + 1;
   localparam int NW  = wtfd_pkg::DIV_NUM_W;
   localparam int CLEAR_LEN = (DELAY_DEPTH > 2 * TABLE_DEPTH) ? DELAY_DEPTH : 2 * TABLE_DEPTH;
   localparam int CLW = $clog2(CLEAR_LEN);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_MUL   = 5'd1;
   localparam logic [4:0] S_DPREP = 5'd2;
   localparam logic [4:0] S_DMOD  = 5'd3;
   localparam logic [4:0] S_TAP   = 5'd4;
   localparam logic [4:0] S_RD2   = 5'd5;
   localparam logic [4:0] S_RD3   = 5'd6;
   localparam logic [4:0] S_INT   = 5'd7;
   localparam logic [4:0] S_OUTS  = 5'd8;
   localparam logic [4:0] S_FBM   = 5'd9;
   localparam logic [4:0] S_FPREP = 5'd10;
   localparam logic [4:0] S_FDIV  = 5'd11;
   localparam logic [4:0] S_G1    = 5'd12;
   localparam logic [4:0] S_G1W   = 5'd13;
   localparam logic [4:0] S_G2    = 5'd14;
   localparam logic [4:0] S_G2W   = 5'd15;
   localparam logic [4:0] S_MIX1  = 5'd16;
   localparam logic [4:0] S_MIX2  = 5'd17;
   localparam logic [4:0] S_MIX3  = 5'd18;
   localparam logic [4:0] S_WR    = 5'd19;
   localparam logic [4:0] S_DONE  = 5'd20;

   // Control state.
   logic [4:0]     state_ff;
   logic [4:0]     state_in;
   logic           clearing_ff;
   logic [CLW-1:0] clr_ff;
   logic [PW-1:0]  phase_ff;
   logic [DW-1:0]  wp_ff;
   logic           active_ff;
   logic [15:0]    fc_ff;
   logic           rsp_valid_ff;
   logic [23:0]    scale_ff;
   logic [15:0]    spms_ff;
   logic [14:0]    dlen_ff;
   logic [15:0]    flen_ff;

   // Datapath registers.
   logic signed [19:0]   freq_ff;
   logic signed [16:0]   dms_ff;
   logic signed [15:0]   fb_ff;
   logic signed [33:0]   d_ff;
   logic [PW-1:0]        inc_ff;
   logic                 mod_ff;
   logic                 gt_ff;
   logic                 eneg_ff;
   logic [15:0]          elo_ff;
   logic [LW+15:0]       dq_ff;
   logic [DW-1:0]        r1_ff;
   logic signed [SB-1:0] s1_ff;
   logic signed [SB-1:0] s2_ff;
   logic signed [SB-1:0] newv_ff;
   logic signed [SB-1:0] oldv_ff;
   logic signed [SB+17:0] ip_ff;
   logic signed [SB:0]   outs_ff;
   logic signed [SB+16:0] fbp_ff;
   logic [16:0]          r_ff;
   logic [16:0]          g1_ff;
   logic [16:0]          g2_ff;
   logic signed [SB+18:0] mp_ff;
   logic signed [SB+2:0] ns_ff;
   logic signed [15:0]   res_sample_ff;
   logic                 res_valid_ff;
   logic                 res_fade_ff;
   logic signed [15:0]   rsp_sample_ff;
   logic                 rsp_svalid_ff;
   logic                 rsp_fade_ff;

   logic accept;
   logic out_free;
   logic fading;
   logic fade_special;
   logic idx_ok;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fading   = fc_ff != 16'd0;
   assign fade_special = (flen_ff == 16'd0) || (fc_ff >= flen_ff);
   assign idx_ok   = IXW'(req_table_index) < IXW'(TABLE_DEPTH);

   // Used delay length, clamped to 1..DELAY_DEPTH.
   logic [LCW-1:0] len_x;
   logic [LW-1:0]  len;
   always_comb begin
      len_x = LCW'(dlen_ff);
      if (len_x == '0) begin
         len = LW'(1);
      end else if (len_x > LCW'(DELAY_DEPTH)) begin
         len = LW'(DELAY_DEPTH);
      end else begin
         len = len_x[LW-1:0];
      end
   end

   // Delay in Q16 samples and its wrap into the line length.
   logic signed [DXW-1:0] dx;
   logic signed [DXW-1:0] lq;
   logic signed [DXW-1:0] ex;
   logic                  d_gt;
   logic                  d_neg;
   logic signed [17:0]    eh;
   logic [16:0]           emag;

   assign dx    = DXW'(d_ff);
   assign lq    = $signed(DXW'({len, 16'd0}));
   assign d_gt  = dx > lq;
   assign d_neg = dx < 0;
   assign ex    = d_gt ? dx - 1 : dx;
   assign eh    = ex[33:16];
   assign emag  = eh[17] ? 17'(-eh) : eh[16:0];

   // Shared divider: floor remainder of the delay, then the fade ratio.
   logic          div_start;
   logic [RW-1:0] div_rem_init;
   logic [NW-1:0] div_num;
   logic [RW-1:0] div_divisor;
   logic          div_done;
   logic [NW-1:0] div_quot;
   logic [RW-1:0] div_rem;

   always_comb begin
      if (state_ff == S_FPREP) begin
         div_start    = !fade_special;
         div_rem_init = RW'(fc_ff);
         div_num      = '0;
         div_divisor  = RW'(flen_ff);
      end else begin
         div_start    = (state_ff == S_DPREP) && (d_gt || d_neg);
         div_rem_init = '0;
         div_num      = emag;
         div_divisor  = RW'(len);
      end
   end

   wtfd_div #(
      .RW (RW),
      .NW (NW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem_init),
      .num      (div_num),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   logic [LW-1:0]  rm_fix;
   logic [LW+15:0] dq_mod;
   assign rm_fix = (eneg_ff && div_rem != '0) ? len - div_rem[LW-1:0] : div_rem[LW-1:0];
   assign dq_mod = {rm_fix, elo_ff} + (LW+16)'(gt_ff);

   // Fade gain unit.
   logic        gain_start;
   logic [16:0] gain_x;
   logic        gain_done;
   logic [16:0] gain_g;

   assign gain_start = (state_ff == S_G1) || (state_ff == S_G2);
   assign gain_x     = (state_ff == S_G1) ? r_ff : wtfd_pkg::GAIN_ONE - r_ff;

   wtfd_gain u_gain (
      .clock (clock),
      .reset (reset),
      .start (gain_start),
      .x     (gain_x),
      .done  (gain_done),
      .g     (gain_g)
   );

   // Tap addresses.
   logic [LW-1:0]  idel;
   logic signed [LW:0] tap_diff;
   logic [DW-1:0]  r1;
   logic [LW-1:0]  r2w;
   logic [DW-1:0]  r2;
   logic [LW-1:0]  wpw;
   logic [DW-1:0]  wp_next;
   logic [TW-1:0]  tix;

   assign idel     = dq_ff[LW+15:16];
   assign tap_diff = $signed({2'b00, wp_ff}) - $signed({1'b0, idel});
   assign r1       = tap_diff[LW] ? DW'(tap_diff + $signed({1'b0, len})) : tap_diff[DW-1:0];
   assign r2w      = {1'b0, r1_ff} + 1'b1;
   assign r2       = (r2w >= len) ? '0 : r2w[DW-1:0];
   assign wpw      = {1'b0, wp_ff} + 1'b1;
   assign wp_next  = (wpw >= len) ? '0 : wpw[DW-1:0];
   assign tix      = phase_ff[PW-1:16];

   // Arithmetic products.
   logic signed [33:0]    dprod;
   logic signed [IPW-1:0] iprod;
   logic signed [SB:0]    sdiff;
   logic signed [SB+17:0] iprod_tap;
   logic signed [SB+1:0]  outs_now;
   logic signed [SB+16:0] fbprod;
   logic signed [SB+17:0] mix_prod;
   logic [16:0]           mix_g;
   logic signed [SB-1:0]  mix_v;

   assign dprod     = dms_ff * $signed({1'b0, spms_ff});
   assign iprod     = freq_ff * $signed({1'b0, scale_ff});
   assign sdiff     = $signed({s2_ff[SB-1], s2_ff}) - $signed({s1_ff[SB-1], s1_ff});
   assign iprod_tap = $signed({1'b0, dq_ff[15:0]}) * sdiff;
   assign outs_now  = (SB+2)'(s1_ff) + ip_ff[SB+17:16];
   assign fbprod    = outs_ff * fb_ff;
   assign mix_g     = (state_ff == S_MIX1) ? g1_ff : g2_ff;
   assign mix_v     = (state_ff == S_MIX1) ? oldv_ff : newv_ff;
   assign mix_prod  = $signed({1'b0, mix_g}) * mix_v;

   // Stored value: oscillator sample plus feedback, saturated.
   localparam logic signed [SB+3:0] SAT_HI = {5'b00000, {(SB-1){1'b1}}};
   localparam logic signed [SB+3:0] SAT_LO = {5'b11111, {(SB-1){1'b0}}};
   logic signed [SB+3:0] wsum;
   logic [SB-1:0]        wval;
   assign wsum = (SB+4)'(ns_ff) + (SB+4)'($signed(fbp_ff[SB+16:15]));
   always_comb begin
      if (wsum > SAT_HI) begin
         wval = SAT_HI[SB-1:0];
      end else if (wsum < SAT_LO) begin
         wval = SAT_LO[SB-1:0];
      end else begin
         wval = wsum[SB-1:0];
      end
   end

   // Table entry saturated to the sample width.
   localparam logic signed [TVW-1:0] TV_HI = TVW'(2 ** (SB - 1) - 1);
   localparam logic signed [TVW-1:0] TV_LO = -TVW'(2 ** (SB - 1));
   logic signed [TVW-1:0] tv_x;
   logic [SB-1:0]         tval;
   assign tv_x = TVW'(req_table_value);
   always_comb begin
      if (tv_x > TV_HI) begin
         tval = TV_HI[SB-1:0];
      end else if (tv_x < TV_LO) begin
         tval = TV_LO[SB-1:0];
      end else begin
         tval = tv_x[SB-1:0];
      end
   end

   // Memories.
   logic           dly_we;
   logic [DW-1:0]  dly_waddr;
   logic [SB-1:0]  dly_wdata;
   logic [DW-1:0]  dly_raddr;
   logic [SB-1:0]  dly_rdata;
   logic           tbl_we;
   logic [TAW-1:0] tbl_waddr;
   logic [SB-1:0]  tbl_wdata;
   logic [TAW-1:0] tbl_raddr;
   logic [SB-1:0]  tbl_rdata;

   always_comb begin
      if (clearing_ff) begin
         dly_we    = 1'b1;
         dly_waddr = clr_ff[DW-1:0];
         dly_wdata = '0;
         tbl_we    = 1'b1;
         tbl_waddr = clr_ff[TAW-1:0];
         tbl_wdata = '0;
      end else begin
         dly_we    = state_ff == S_WR;
         dly_waddr = wp_ff;
         dly_wdata = wval;
         tbl_we    = accept && (req_mode == wtfd_pkg::MODE_WRITE) && idx_ok;
         tbl_waddr = {~active_ff, TW'(req_table_index)};
         tbl_wdata = tval;
      end
   end

   assign dly_raddr = (state_ff == S_TAP) ? r1 : r2;
   assign tbl_raddr = (state_ff == S_TAP) ? {active_ff, tix} : {~active_ff, tix};

   wtfd_ram #(
      .WIDTH (SB),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_ram (
      .clock (clock),
      .we    (dly_we),
      .waddr (dly_waddr),
      .wdata (dly_wdata),
      .raddr (dly_raddr),
      .rdata (dly_rdata)
   );

   wtfd_ram #(
      .WIDTH (SB),
      .DEPTH (2 * TABLE_DEPTH)
   ) u_table_ram (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_mode == wtfd_pkg::MODE_AUDIO) ? S_MUL : S_DONE;
            end
         end
         S_MUL:   state_in = S_DPREP;
         S_DPREP: state_in = S_DMOD;
         S_DMOD: begin
            if (!mod_ff || div_done) begin
               state_in = S_TAP;
            end
         end
         S_TAP:  state_in = S_RD2;
         S_RD2:  state_in = S_RD3;
         S_RD3:  state_in = S_INT;
         S_INT:  state_in = S_OUTS;
         S_OUTS: state_in = S_FBM;
         S_FBM:  state_in = fading ? S_FPREP : S_WR;
         S_FPREP: state_in = fade_special ? S_G1 : S_FDIV;
         S_FDIV: begin
            if (div_done) begin
               state_in = S_G1;
            end
         end
         S_G1: state_in = S_G1W;
         S_G1W: begin
            if (gain_done) begin
               state_in = S_G2;
            end
         end
         S_G2: state_in = S_G2W;
         S_G2W: begin
            if (gain_done) begin
               state_in = S_MIX1;
            end
         end
         S_MIX1: state_in = S_MIX2;
         S_MIX2: state_in = S_MIX3;
         S_MIX3: state_in = S_WR;
         S_WR:   state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         phase_ff     <= '0;
         wp_ff        <= '0;
         active_ff    <= 1'b0;
         fc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         scale_ff     <= wtfd_pkg::INC_SCALE_RST;
         spms_ff      <= wtfd_pkg::SPMS_RST;
         dlen_ff      <= wtfd_pkg::DLEN_RST;
         flen_ff      <= wtfd_pkg::FLEN_RST;
      end else begin
         state_ff <= state_in;
         if (clearing_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (clr_ff == CLW'(CLEAR_LEN - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (csr_valid) begin
            unique case (csr_index)
               wtfd_pkg::CSR_INC_SCALE: scale_ff <= csr_wdata;
               wtfd_pkg::CSR_SPMS:      spms_ff  <= csr_wdata[15:0];
               wtfd_pkg::CSR_DLEN:      dlen_ff  <= csr_wdata[14:0];
               wtfd_pkg::CSR_FLEN:      flen_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && req_mode == wtfd_pkg::MODE_COMMIT) begin
            active_ff <= ~active_ff;
            fc_ff     <= flen_ff;
         end
         if (state_ff == S_MUL && {1'b0, wp_ff} >= len) begin
            wp_ff <= '0;
         end
         if (state_ff == S_WR) begin
            wp_ff    <= wp_next;
            phase_ff <= phase_ff + inc_ff;
            if (fading) begin
               fc_ff <= fc_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         freq_ff       <= req_frequency_hz;
         dms_ff        <= req_delay_ms;
         fb_ff         <= req_feedback_gain;
         res_sample_ff <= '0;
         res_valid_ff  <= 1'b0;
         unique case (req_mode)
            wtfd_pkg::MODE_COMMIT: res_fade_ff <= flen_ff != 16'd0;
            default:               res_fade_ff <= fading;
         endcase
      end
      unique case (state_ff)
         S_MUL: begin
            d_ff   <= dprod;
            inc_ff <= iprod[PW+11:12];
         end
         S_DPREP: begin
            mod_ff  <= d_gt || d_neg;
            gt_ff   <= d_gt;
            eneg_ff <= eh[17];
            elo_ff  <= ex[15:0];
         end
         S_DMOD: begin
            dq_ff <= mod_ff ? dq_mod : dx[LW+15:0];
         end
         S_TAP: begin
            r1_ff <= r1;
         end
         S_RD2: begin
            s1_ff   <= $signed(dly_rdata);
            newv_ff <= $signed(tbl_rdata);
         end
         S_RD3: begin
            s2_ff   <= $signed(dly_rdata);
            oldv_ff <= $signed(tbl_rdata);
         end
         S_INT: begin
            ip_ff <= iprod_tap;
         end
         S_OUTS: begin
            outs_ff <= outs_now[SB:0];
         end
         S_FBM: begin
            fbp_ff <= fbprod;
            ns_ff  <= (SB+3)'(newv_ff);
         end
         S_FPREP: begin
            r_ff <= wtfd_pkg::GAIN_ONE;
         end
         S_FDIV: begin
            if (div_done) begin
               r_ff <= {1'b0, div_quot[NW-1:1]};
            end
         end
         S_G1W: begin
            if (gain_done) begin
               g1_ff <= gain_g;
            end
         end
         S_G2W: begin
            if (gain_done) begin
               g2_ff <= gain_g;
            end
         end
         S_MIX1: begin
            mp_ff <= (SB+19)'(mix_prod);
         end
         S_MIX2: begin
            mp_ff <= mp_ff + (SB+19)'(mix_prod);
         end
         S_MIX3: begin
            ns_ff <= mp_ff[SB+18:16];
         end
         S_WR: begin
            res_sample_ff <= 16'(outs_ff);
            res_valid_ff  <= 1'b1;
            res_fade_ff   <= fading;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_sample_ff <= res_sample_ff;
               rsp_svalid_ff <= res_valid_ff;
               rsp_fade_ff   <= res_fade_ff;
            end
         end
         default: ;
      endcase
   end

   assign req_stall        = reset || clearing_ff || (state_ff != S_IDLE);
   assign csr_ready        = !reset;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_sample   = rsp_sample_ff;
   assign rsp_sample_valid = rsp_svalid_ff;
   assign rsp_fade_active  = rsp_fade_ff;

endmodule

[hdl/wtfd_checker.sv]
`timescale 1ns / 1ps

module wtfd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_out_sample,
   input logic               rsp_sample_valid,
   input logic               rsp_fade_active
);

   // No result may be left standing across reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat visible after reset");

   // One beat is processed at a time, so an accepted beat closes the input.
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken twice in a row");

   // Table writes, commits and ignored beats carry a zero sample.
   a_zero_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sample_valid) |-> rsp_out_sample == 16'sd0)
      else $error("non-audio result carries a sample");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_sample)
         && $stable(rsp_sample_valid) && $stable(rsp_fade_active)))
      else $error("stalled result changed");

endmodule

bind wavetable_osc_feedback_delay wtfd_checker u_wtfd_checker (.*);

[dv/wavetable_osc_feedback_delay_tb.sv]
`timescale 1ns / 1ps

module wavetable_osc_feedback_delay_tb;

   // The block ignores this mode, but the field allows it.
   localparam logic [1:0] MODE_IGNORED = 2'd3;

   typedef struct {
      logic [1:0]         mode;
      logic signed [19:0] freq;
      logic signed [16:0] dms;
      logic signed [15:0] fb;
      logic [11:0]        tidx;
      logic signed [15:0] tval;
   } beat_type;

   typedef struct {
      logic signed [15:0] sample;
      logic               svalid;
      logic               fade;
   } audio_out_type;

   class osc_scoreboard;
      longint inc_scale, spms, dlen, flen;
      longint phase_acc;
      longint wpos;
      logic signed [15:0] line_mem[wtfd_pkg::DELAY_DEPTH_DEF];
      logic signed [15:0] wave_mem[2*wtfd_pkg::TABLE_DEPTH_DEF];
      bit bank;
      longint fcount;
      audio_out_type pending[$];
      int n_audio, n_writes, n_commits, n_ignored;

      function new();
         inc_scale = longint'(wtfd_pkg::INC_SCALE_RST);
         spms = longint'(wtfd_pkg::SPMS_RST);
         dlen = longint'(wtfd_pkg::DLEN_RST);
         flen = longint'(wtfd_pkg::FLEN_RST);
         phase_acc = 0;
         wpos = 0;
         bank = 1'b0;
         fcount = 0;
         foreach (line_mem[i]) line_mem[i] = '0;
         foreach (wave_mem[i]) wave_mem[i] = '0;
      endfunction

      function void configure(logic [1:0] idx, logic [23:0] val);
         case (idx)
            wtfd_pkg::CSR_INC_SCALE: inc_scale = longint'(val);
            wtfd_pkg::CSR_SPMS: spms = longint'(val[15:0]);
            wtfd_pkg::CSR_DLEN: dlen = longint'(val[14:0]);
            wtfd_pkg::CSR_FLEN: flen = longint'(val[15:0]);
         endcase
      endfunction

      function longint wrap(longint v, longint m);
         longint r;
         r = v % m;
         if (r < 0) r += m;
         return r;
      endfunction

      function longint sat16(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function longint gain(longint x);
         longint x2, t, u, g;
         x2 = (x * x) >> 16;
         t = longint'(wtfd_pkg::FADE_A3) - ((x2 * longint'(wtfd_pkg::FADE_A5)) >> 16);
         u = longint'(wtfd_pkg::FADE_A1) - ((x2 * t) >> 16);
         g = (x * u) >> 16;
         return (g > 65536) ? 65536 : g;
      endfunction

      function void note(beat_type b);
         audio_out_type e;
         longint L, Lq, D, idel, frac, r1, r2, s1, s2, outs, fbs, ns, tix, nv, ov, r, inc;
         bit fading;
         e.sample = '0;
         e.svalid = 1'b0;
         if (b.mode == wtfd_pkg::MODE_WRITE) begin
            wave_mem[{~bank, b.tidx}] = b.tval;
            n_writes++;
         end else if (b.mode == wtfd_pkg::MODE_COMMIT) begin
            bank = ~bank;
            fcount = flen;
            n_commits++;
         end else if (b.mode == MODE_IGNORED) begin
            n_ignored++;
         end
         e.fade = fcount != 0;
         if (b.mode == wtfd_pkg::MODE_AUDIO) begin
            fading = fcount != 0;
            L = dlen;
            if (L < 1) L = 1;
            if (L > wtfd_pkg::DELAY_DEPTH_DEF) L = wtfd_pkg::DELAY_DEPTH_DEF;
            if (wpos >= L) wpos = 0;
            Lq = L << 16;
            D = longint'(b.dms) * spms;
            if (D > Lq) D = wrap(D - 1, Lq) + 1;
            else if (D < 0) D = wrap(D, Lq);
            idel = D >> 16;
            frac = D & 65535;
            r1 = wrap(wpos - idel, L);
            r2 = r1 + 1;
            if (r2 >= L) r2 = 0;
            s1 = longint'(line_mem[r1]);
            s2 = longint'(line_mem[r2]);
            outs = s1 + ((frac * (s2 - s1)) >>> 16);
            fbs = (outs * longint'(b.fb)) >>> 15;
            tix = phase_acc >> 16;
            nv = longint'(wave_mem[{bank, tix[11:0]}]);
            ov = longint'(wave_mem[{~bank, tix[11:0]}]);
            if (fading) begin
               if (flen == 0 || fcount >= flen) r = 65536;
               else r = (fcount << 16) / flen;
               ns = (gain(r) * ov + gain(65536 - r) * nv) >>> 16;
               fcount--;
            end else begin
               ns = nv;
            end
            line_mem[wpos] = 16'(sat16(ns + fbs));
            wpos++;
            if (wpos >= L) wpos = 0;
            inc = (longint'(b.freq) * inc_scale) >>> 12;
            phase_acc = wrap(phase_acc + inc, longint'(wtfd_pkg::TABLE_DEPTH_DEF) << 16);
            e.sample = 16'(sat16(outs));
            e.svalid = 1'b1;
            e.fade = fading;
            n_audio++;
         end
         pending.push_back(e);
      endfunction

      // Returns 1 on a mismatch or an unexpected result, with the reason in why.
      function bit check(audio_out_type got, output string why);
         audio_out_type e;
         if (pending.size() == 0) begin
            why = "result beat with nothing expected";
            return 1;
         end
         e = pending.pop_front();
         if (got.sample !== e.sample || got.svalid !== e.svalid || got.fade !== e.fade) begin
            $sformat(why, "got sample %0d valid %0b fade %0b, expected %0d %0b %0b",
                     got.sample, got.svalid, got.fade, e.sample, e.svalid, e.fade);
            return 1;
         end
         why = "";
         return 0;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic signed [19:0] req_frequency_hz = '0;
   logic signed [16:0] req_delay_ms = '0;
   logic signed [15:0] req_feedback_gain = '0;
   logic [11:0] req_table_index = '0;
   logic signed [15:0] req_table_value = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_out_sample;
   logic rsp_sample_valid;
   logic rsp_fade_active;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   osc_scoreboard osc_sb = new();
   int mismatches = 0;
   int results_seen = 0;
   int settings_run = 0;
   bit noisy = 1;
   int hold_asks = 0;
   int hold_taken = 0;
   int hold_left = 0;

   wavetable_osc_feedback_delay dut (.*);

   always #10 clock = ~clock;

   task automatic report_mismatch(string why);
      $display("mismatch at %0t: %s", $realtime, why);
      mismatches++;
   endtask

   always @(posedge clock) begin
      audio_out_type got;
      beat_type b;
      string why;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            b.mode = req_mode;
            b.freq = req_frequency_hz;
            b.dms = req_delay_ms;
            b.fb = req_feedback_gain;
            b.tidx = req_table_index;
            b.tval = req_table_value;
            osc_sb.note(b);
         end
         if (rsp_valid && !rsp_stall) begin
            got.sample = rsp_out_sample;
            got.svalid = rsp_sample_valid;
            got.fade = rsp_fade_active;
            results_seen++;
            if (osc_sb.check(got, why)) report_mismatch(why);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when asked.
   always @(posedge clock) begin
      if (hold_asks != hold_taken) begin
         hold_taken <= hold_asks;
         hold_left <= 400;
         rsp_stall <= 1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= noisy && ($urandom_range(99) < 11);
      end
   end

   task automatic send_beat(beat_type b);
      if (noisy && $urandom_range(99) < 11) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_mode <= b.mode;
      req_frequency_hz <= b.freq;
      req_delay_ms <= b.dms;
      req_feedback_gain <= b.fb;
      req_table_index <= b.tidx;
      req_table_value <= b.tval;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write.
   task automatic write_csr(logic [1:0] idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      osc_sb.configure(idx, val);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (osc_sb.pending.size() != 0) @(posedge clock);
      // Table writes and commits may still be finishing.
      repeat (100) @(posedge clock);
   endtask

   function automatic beat_type mk(logic [1:0] m, int f, int d, int g, int ti, int tv);
      beat_type b;
      b.mode = m;
      b.freq = 20'(f);
      b.dms = 17'(d);
      b.fb = 16'(g);
      b.tidx = 12'(ti);
      b.tval = 16'(tv);
      return b;
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      int pick;
      pick = int'($urandom_range(99));
      b.freq = 20'($urandom);
      b.fb = 16'($urandom);
      b.tval = 16'($urandom);
      b.tidx = 12'($urandom);
      if ($urandom_range(1)) b.dms = 17'($urandom);
      else b.dms = 17'(int'($urandom_range(2000)) - 1000);
      // Half the table writes land on the entry the oscillator is reading.
      if ($urandom_range(1)) b.tidx = 12'(osc_sb.phase_acc >> 16);
      if (pick < 78) b.mode = wtfd_pkg::MODE_AUDIO;
      else if (pick < 92) b.mode = wtfd_pkg::MODE_WRITE;
      else if (pick < 97) b.mode = wtfd_pkg::MODE_COMMIT;
      else b.mode = MODE_IGNORED;
      return b;
   endfunction

   task automatic run_setting(logic [23:0] inc, logic [23:0] sp, logic [23:0] dl,
                              logic [23:0] fl, bit quiet, bit squeeze, int count);
      drain();
      write_csr(wtfd_pkg::CSR_INC_SCALE, inc);
      write_csr(wtfd_pkg::CSR_SPMS, sp);
      write_csr(wtfd_pkg::CSR_DLEN, dl);
      write_csr(wtfd_pkg::CSR_FLEN, fl);
      csr_valid <= 0;
      noisy = !quiet;
      settings_run++;
      for (int i = 0; i < count; i++) begin
         if (squeeze && i == count / 2) hold_asks++;
         send_beat(random_beat());
      end
      noisy = 1;
   endtask

   initial begin
      beat_type directed[$];
      int waited;
      repeat (4) @(posedge clock);
      reset <= 0;

      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 0, 0, 0, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_WRITE, 0, 0, 0, 0, 32767));
      directed.push_back(mk(wtfd_pkg::MODE_WRITE, 0, 0, 0, 4095, -32768));
      directed.push_back(mk(wtfd_pkg::MODE_WRITE, 0, 0, 0, 1, 1234));
      directed.push_back(mk(wtfd_pkg::MODE_COMMIT, 0, 0, 0, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 524287, 65535, 32767, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, -524288, -65536, -32768, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_WRITE, 0, 0, 0, 0, -20000));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 16, 256, 16384, 0, 0));
      directed.push_back(mk(MODE_IGNORED, 524287, 65535, 32767, 4095, 32767));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 0, 1, -16384, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_COMMIT, 0, 0, 0, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 160, 0, 32767, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, -160, -1, 32767, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 1, 64000, -32768, 0, 0));
      directed.push_back(mk(wtfd_pkg::MODE_WRITE, 0, 0, 0, 2048, 1));
      directed.push_back(mk(wtfd_pkg::MODE_AUDIO, 0, 300, 32767, 0, 0));
      foreach (directed[i]) send_beat(directed[i]);

      run_setting(24'd1431656, 24'd12288, 24'd7, 24'd5, 0, 0, 265);
      run_setting(24'd0, 24'd65535, 24'd0, 24'd0, 0, 0, 265);
      run_setting(24'hFFFFFF, 24'd0, 24'h7FFF, 24'd1, 1, 0, 265);
      run_setting(24'd4096, 24'd256, 24'd16384, 24'd65535, 0, 1, 265);
      run_setting(24'd100000, 24'd3000, 24'd64, 24'd40, 0, 0, 265);

      req_valid <= 0;
      waited = 0;
      while (osc_sb.pending.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (osc_sb.pending.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   osc_sb.pending.size()));
      $display("Covered %0d audio samples, %0d table writes, %0d commits, %0d ignored beats",
               osc_sb.n_audio, osc_sb.n_writes, osc_sb.n_commits, osc_sb.n_ignored);
      $display("over %0d register settings plus reset values; %0d results checked",
               settings_run, results_seen);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("timeout");
      $display("FAIL");
      $finish;
   end

endmodule
